>>> hdl/tmrb_pkg.sv
// Shared types, codes and constants of the timer bank.
package tmrb_pkg;

    // Bank geometry and base tick
    localparam int TIMER_SLOTS  = 16;
    localparam int IDX_W        = $clog2(TIMER_SLOTS);
    localparam int BASE_TICK_MS = 10;

    // Field widths
    localparam int OP_W     = 2;
    localparam int SLOT_W   = 4;
    localparam int PERIOD_W = 20;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 17;

    // Reset value of the maximum period register
    localparam logic [PERIOD_W-1:0] MAX_PERIOD_RST = PERIOD_W'(1000000);

    // Reciprocal for period / BASE_TICK_MS: exact for any 20-bit period
    localparam int RECIP_SHIFT = 23;
    localparam int RECIP_W     = 20;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((2 ** RECIP_SHIFT + BASE_TICK_MS - 1) / BASE_TICK_MS);
    localparam int PROD_W = PERIOD_W + RECIP_W;

    // Operation codes on the input
    localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
    localparam logic [OP_W-1:0] OP_CREATE = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;
    localparam logic [OP_W-1:0] OP_RESET  = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_SLOT = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

    // Result kinds
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_FIRED  = 1'b1;

    // Mode bits
    localparam int MODE_ONCE_BIT     = 0;
    localparam int MODE_PERIODIC_BIT = 1;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [SLOT_W-1:0]   slot;
        logic [PERIOD_W-1:0] period_ms;
        logic [MODE_W-1:0]   mode;
    } in_beat_t;

    typedef struct packed {
        logic                kind;
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot_out;
        logic                last;
    } out_beat_t;

    // Classified command as the front hands it to the back
    typedef enum logic [2:0] {
        CMD_TICK,
        CMD_CREATE,
        CMD_BAD_PERIOD,
        CMD_DELETE,
        CMD_RESET
    } cmd_t;

    typedef struct packed {
        cmd_t               cmd;
        logic [SLOT_W-1:0]  slot;
        logic [MODE_W-1:0]  mode;
        logic [COUNT_W-1:0] count;
    } cmd_entry_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_WALK,
        BK_LAST
    } bk_state_t;

endpackage

>>> hdl/tmrb_front.sv
// Front end: accepts input beats, checks the period, converts it to ticks.
module tmrb_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  tmrb_pkg::in_beat_t             in_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tmrb_pkg::PERIOD_W-1:0]  cfg_data,
    output logic                           push,
    output tmrb_pkg::cmd_entry_t           push_data,
    input  logic                           q_full
);
    import tmrb_pkg::*;

    logic [PERIOD_W-1:0] max_period_reg;
    logic [PERIOD_W-1:0] max_period_next;
    logic [PROD_W-1:0]   prod;
    logic                period_bad;

    // Take a config beat at any time
    assign cfg_ready = 1'b1;

    always_comb
    begin
        max_period_next = max_period_reg;
        if (cfg_valid && cfg_ready)
        begin
            max_period_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_period_reg <= MAX_PERIOD_RST;
        end
        else
        begin
            max_period_reg <= max_period_next;
        end
    end

    // Stall while the queue has no room
    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    // Divide by the base tick; the quotient of a 20-bit period fits the count
    assign prod       = PROD_W'(in_data.period_ms) * PROD_W'(RECIP);
    assign period_bad = (in_data.period_ms < PERIOD_W'(BASE_TICK_MS))
                     || (in_data.period_ms > max_period_reg);

    // Classify the beat
    always_comb
    begin
        push_data.slot  = in_data.slot;
        push_data.mode  = in_data.mode;
        push_data.count = prod[RECIP_SHIFT +: COUNT_W];
        case (in_data.op)
            OP_TICK:   push_data.cmd = CMD_TICK;
            OP_CREATE: push_data.cmd = period_bad ? CMD_BAD_PERIOD : CMD_CREATE;
            OP_DELETE: push_data.cmd = CMD_DELETE;
            OP_RESET:  push_data.cmd = CMD_RESET;
            default:   push_data.cmd = CMD_TICK;
        endcase
    end

endmodule

>>> hdl/tmrb_queue.sv
// Two-entry command queue between front and back.
module tmrb_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  tmrb_pkg::cmd_entry_t  push_data,
    output logic                  full,
    input  logic                  pop,
    output logic                  head_valid,
    output tmrb_pkg::cmd_entry_t  head
);
    import tmrb_pkg::*;

    cmd_entry_t  mem_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;

    assign full       = (cnt_reg == 2'd2);
    assign head_valid = (cnt_reg != 2'd0);
    assign head       = mem_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the pushed entry
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue pop while empty");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("queue occupancy out of range");

endmodule

>>> hdl/tmrb_back.sv
// Back end: slot state, command execution, tick walk and result register.
module tmrb_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  head_valid,
    input  tmrb_pkg::cmd_entry_t  head,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output tmrb_pkg::out_beat_t   out_data
);
    import tmrb_pkg::*;

    bk_state_t                state_reg;
    bk_state_t                state_next;
    logic [IDX_W-1:0]         idx_reg;
    logic [IDX_W-1:0]         idx_next;
    logic                     pend_valid_reg;
    logic                     pend_valid_next;
    logic [IDX_W-1:0]         pend_slot_reg;
    logic [IDX_W-1:0]         pend_slot_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    out_beat_t                out_data_reg;
    out_beat_t                out_data_next;

    logic [TIMER_SLOTS-1:0]   slot_used_reg;
    logic [TIMER_SLOTS-1:0]   slot_stopped_reg;
    logic [COUNT_W-1:0]       tick_count_reg   [TIMER_SLOTS];
    logic [COUNT_W-1:0]       reload_count_reg [TIMER_SLOTS];
    logic [MODE_W-1:0]        slot_mode_reg    [TIMER_SLOTS];

    logic                     out_free;
    logic                     free_any;
    logic [IDX_W-1:0]         free_idx;
    logic [IDX_W-1:0]         addr;
    logic                     rd_used;
    logic                     rd_stopped;
    logic [COUNT_W-1:0]       rd_cnt;
    logic [COUNT_W-1:0]       rd_rel;
    logic [MODE_W-1:0]        rd_mode;
    logic                     slot_range_bad;
    logic                     active;
    logic                     fire;
    logic                     new_stopped;
    logic                     step_en;
    logic                     idx_last;

    logic                     wr_en;
    logic                     wr_used;
    logic                     wr_stopped;
    logic [COUNT_W-1:0]       wr_cnt;
    logic [COUNT_W-1:0]       wr_rel;
    logic [MODE_W-1:0]        wr_mode;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    // Find the lowest free slot
    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = TIMER_SLOTS - 1; i >= 0; i--)
        begin
            if (!slot_used_reg[i])
            begin
                free_any = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    // Select the one slot touched this cycle
    always_comb
    begin
        if (state_reg == BK_WALK)
        begin
            addr = idx_reg;
        end
        else if (head.cmd == CMD_CREATE)
        begin
            addr = free_idx;
        end
        else
        begin
            addr = IDX_W'(head.slot);
        end
    end

    assign rd_used        = slot_used_reg[addr];
    assign rd_stopped     = slot_stopped_reg[addr];
    assign rd_cnt         = tick_count_reg[addr];
    assign rd_rel         = reload_count_reg[addr];
    assign rd_mode        = slot_mode_reg[addr];
    assign slot_range_bad = (int'(head.slot) >= TIMER_SLOTS);

    // Evaluate the walked slot
    assign active      = rd_used && !rd_stopped && (rd_cnt != '0);
    assign fire        = active && (rd_cnt == COUNT_W'(1));
    assign new_stopped = rd_stopped || (fire && rd_mode[MODE_ONCE_BIT]);
    assign step_en     = !(fire && pend_valid_reg && !out_free);
    assign idx_last    = (idx_reg == IDX_W'(TIMER_SLOTS - 1));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (head_valid && (head.cmd == CMD_TICK))
                begin
                    state_next = BK_WALK;
                end
            end
            BK_WALK:
            begin
                if (step_en && idx_last)
                begin
                    state_next = BK_LAST;
                end
            end
            BK_LAST:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Datapath, slot writes and results
    always_comb
    begin
        pop             = 1'b0;
        idx_next        = idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_data_next   = out_data_reg;
        wr_en           = 1'b0;
        wr_used         = rd_used;
        wr_stopped      = rd_stopped;
        wr_cnt          = rd_cnt;
        wr_rel          = rd_rel;
        wr_mode         = rd_mode;
        case (state_reg)
            BK_IDLE:
            begin
                if (head_valid && (head.cmd == CMD_TICK))
                begin
                    pop = 1'b1;
                end
                else if (head_valid && out_free)
                begin
                    pop                    = 1'b1;
                    out_valid_next         = 1'b1;
                    out_data_next.kind     = KIND_STATUS;
                    out_data_next.status   = ST_OK;
                    out_data_next.slot_out = '0;
                    out_data_next.last     = 1'b1;
                    case (head.cmd)
                        CMD_BAD_PERIOD:
                        begin
                            out_data_next.status = ST_RANGE;
                        end
                        CMD_CREATE:
                        begin
                            if (free_any)
                            begin
                                wr_en                  = 1'b1;
                                wr_used                = 1'b1;
                                wr_stopped             = 1'b0;
                                wr_mode                = head.mode;
                                wr_cnt                 = head.count;
                                wr_rel                 = head.count;
                                out_data_next.slot_out = SLOT_W'(free_idx);
                            end
                            else
                            begin
                                out_data_next.status = ST_FULL;
                            end
                        end
                        CMD_DELETE:
                        begin
                            if (slot_range_bad || !rd_used)
                            begin
                                out_data_next.status = ST_BAD_SLOT;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_stopped = 1'b1;
                            end
                        end
                        CMD_RESET:
                        begin
                            if (slot_range_bad || !rd_used)
                            begin
                                out_data_next.status = ST_BAD_SLOT;
                            end
                            else
                            begin
                                wr_en  = 1'b1;
                                wr_cnt = rd_rel;
                            end
                        end
                        default:
                        begin
                            out_data_next.status = ST_OK;
                        end
                    endcase
                end
            end
            BK_WALK:
            begin
                if (step_en)
                begin
                    wr_en      = 1'b1;
                    wr_stopped = new_stopped;
                    if (active)
                    begin
                        wr_cnt = rd_cnt - COUNT_W'(1);
                    end
                    if (fire && rd_mode[MODE_PERIODIC_BIT])
                    begin
                        wr_cnt = rd_rel;
                    end
                    // Free a stopped slot at the end of its tick
                    if (rd_used && new_stopped)
                    begin
                        wr_used    = 1'b0;
                        wr_stopped = 1'b0;
                        wr_cnt     = '0;
                        wr_rel     = '0;
                        wr_mode    = '0;
                    end
                    // Hold the newest event until the next one shows it is not last
                    if (fire)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next         = 1'b1;
                            out_data_next.kind     = KIND_FIRED;
                            out_data_next.status   = ST_OK;
                            out_data_next.slot_out = SLOT_W'(pend_slot_reg);
                            out_data_next.last     = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_slot_next  = idx_reg;
                    end
                    idx_next = idx_last ? '0 : idx_reg + IDX_W'(1);
                end
            end
            BK_LAST:
            begin
                if (pend_valid_reg && out_free)
                begin
                    out_valid_next         = 1'b1;
                    out_data_next.kind     = KIND_FIRED;
                    out_data_next.status   = ST_OK;
                    out_data_next.slot_out = SLOT_W'(pend_slot_reg);
                    out_data_next.last     = 1'b1;
                    pend_valid_next        = 1'b0;
                end
            end
            default:
            begin
                pend_valid_next = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= BK_IDLE;
            idx_reg          <= '0;
            pend_valid_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
            slot_used_reg    <= '0;
            slot_stopped_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (wr_en)
            begin
                slot_used_reg[addr]    <= wr_used;
                slot_stopped_reg[addr] <= wr_stopped;
            end
        end
    end

    // Payload registers; counts of a free slot are never read before create
    always_ff @(posedge clk)
    begin
        pend_slot_reg <= pend_slot_next;
        out_data_reg  <= out_data_next;
        if (wr_en)
        begin
            tick_count_reg[addr]   <= wr_cnt;
            reload_count_reg[addr] <= wr_rel;
            slot_mode_reg[addr]    <= wr_mode;
        end
    end

    a_stopped_is_used: assert property (@(posedge clk) disable iff (!rst_n)
        (slot_stopped_reg & ~slot_used_reg) == '0)
        else $error("stopped slot not in use");

    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_IDLE) |-> (!pend_valid_reg && (idx_reg == '0)))
        else $error("walk state left over in idle");

    a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_data_reg.kind == KIND_STATUS)) |-> out_data_reg.last)
        else $error("command status not marked last");

    a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == BK_LAST) && !pend_valid_reg) |=> (state_reg == BK_IDLE))
        else $error("walk end did not return to idle");

endmodule

>>> hdl/timer_bank_one_shot_periodic_core.sv
// Top level of the timer bank: front end, command queue and back end.
//
//  channel   direction  handshake          beat
//  in        input      in_valid/in_stall   in_beat_t  (op, slot, period_ms, mode)
//  out       output     out_valid/out_stall out_beat_t (kind, status, slot_out, last)
//  cfg       input      cfg_valid/cfg_ready max_period, 20 bits
//
// Create, delete and reset: the accepted command is registered in the queue, executes when it
// reaches the head while the back end is idle and the output is free, and its status beat is registered.
// A tick holds the back end while it pops the command, walks the slots one by one and
// flushes the last event, and it waits while the output is stalled with an event still waiting.
// The queue holds two commands, so the front accepts beats during a walk.
// Reset clears all slots to free; the max period register resets to 1000000.
module timer_bank_one_shot_periodic_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  tmrb_pkg::in_beat_t             in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output tmrb_pkg::out_beat_t            out_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tmrb_pkg::PERIOD_W-1:0]  cfg_data
);
    import tmrb_pkg::*;

    logic        push;
    cmd_entry_t  push_data;
    logic        q_full;
    logic        pop;
    logic        head_valid;
    cmd_entry_t  head;

    tmrb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .push      (push),
        .push_data (push_data),
        .q_full    (q_full)
    );

    tmrb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    tmrb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule
